// File: rtl/core/bb3_pkg.sv
// Package for the 3x3 binomial blur block: field widths, register codes
// and fixed limits shared by the channel interfaces and the top level.
// Depends on nothing.
package bb3_pkg;

   localparam int SAMPLE_W    = 16;   // height sample and smoothed result
   localparam int LEN_REG_W   = 9;    // line_length register
   localparam int CNT_REG_W   = 11;   // line_count register
   localparam int CSR_DATA_W  = 11;   // widest register
   localparam int CSR_INDEX_W = 1;
   localparam int MAX_LINES   = 1024; // upper clamp of line_count
   localparam int MIN_DIM     = 3;    // lower clamp of both registers
   localparam int ROW_W       = 11;   // line counter, reaches line_count + 1
   localparam int SUM_W       = 20;   // 16 times the largest sample

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COUNT  = 1'b1;

endpackage

// File: rtl/core/bb3_if.sv
// Valid/ready channel interfaces of the 3x3 binomial blur block: request,
// response and register write channels.
// Depends on bb3_pkg.
interface bb3_req_if import bb3_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                is_flush;

   modport source (output valid, output sample, output is_flush, input ready);
   modport sink   (input valid, input sample, input is_flush, output ready);
endinterface

interface bb3_rsp_if import bb3_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] smoothed;
   logic                frame_last;

   modport source (output valid, output smoothed, output frame_last, input ready);
   modport sink   (input valid, input smoothed, input frame_last, output ready);
endinterface

interface bb3_csr_if import bb3_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/binomial_blur_3x3_top.sv
// Top level of the 3x3 binomial blur block: input register, line stores,
// window, kernel adder tree and response register.
// Depends on bb3_pkg and the channel interfaces in bb3_if.sv.

// The block smooths a grid of 16-bit heights that arrives in scan order, one
// sample per request, with the kernel 1-2-1 / 2-4-2 / 1-2-1 divided by 16 and
// truncated; samples on the grid border come out unchanged. It takes one
// request per clock cycle when the response side keeps up: an accepted request
// waits in the input register, where the kernel sum and the position checks
// are done on line store data read one step ahead. The result of the step
// then goes into the response register, which holds it until the response
// side takes it, which frees it for the next step. In items, responses
// lag by one line plus one sample: the response for a position is released by
// the request one line and one sample later, so after the last sample of a grid
// line_length + 1 flush requests push out the rest; flushes with nothing owed
// give no response. A register write restarts the grid and drops owed results,
// and a sample after a finished grid starts the next grid the same way.
// line_length is clamped to 3..MAX_LINE and line_count to 3..1024 when written.
// The two line stores are single memories of MAX_LINE entries with one write
// and one registered read each; they need no clearing after reset.
module binomial_blur_3x3_top
   import bb3_pkg::*;
#(
   parameter int MAX_LINE = 256
) (
   input  logic clock,
   input  logic reset,
   bb3_req_if.sink   req_if,
   bb3_rsp_if.source rsp_if,
   bb3_csr_if.sink   csr_if
);

   localparam int COL_W     = $clog2(MAX_LINE);
   localparam int LEN_W     = $clog2(MAX_LINE + 1);
   localparam int PEND_W    = $clog2(MAX_LINE + 2);
   localparam int LEN_RESET = (MAX_LINE < 256) ? MAX_LINE : 256;
   localparam int CNT_RESET = 256;

   // Line stores: upper holds the line two above the input, middle one above.
   logic [SAMPLE_W-1:0] store_up_mem  [MAX_LINE];
   logic [SAMPLE_W-1:0] store_mid_mem [MAX_LINE];
   logic [SAMPLE_W-1:0] rd_up_ff, rd_mid_ff;
   logic [COL_W-1:0]    rd_addr;

   // Input register.
   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_flush_ff;

   // Grid position and drain state.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              done_ff, done_in;
   logic [LEN_W-1:0]  len_ff;
   logic [ROW_W-1:0]  cnt_ff;

   // Window: [0..2] newest column (top, middle, bottom), [3..5] the one before.
   logic [SAMPLE_W-1:0] window_ff [6];

   // Response register.
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_smoothed_ff;
   logic                rsp_last_ff;

   logic                fire, adv, restart_now, csr_wr, wrap, have_out;
   logic                interior, is_last;
   logic [COL_W-1:0]    col_use, col_nxt;
   logic [ROW_W-1:0]    row_use, row_nxt, orow;
   logic [LEN_W-1:0]    ocol;
   logic [SAMPLE_W-1:0] v;
   logic [SUM_W-1:0]    corner_sum, edge_sum, kernel_sum;
   logic [SAMPLE_W-1:0] out_value;
   logic [31:0]         len_wr, cnt_wr;
   logic [LEN_W-1:0]    len_clamped;
   logic [ROW_W-1:0]    cnt_clamped;

   assign csr_wr       = csr_if.valid && csr_if.ready;
   assign csr_if.ready = 1'b1;

   // The request in the input register moves on when the response register is
   // free or being emptied; requests without a response move on the same way.
   assign fire         = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || fire;

   // A flush with nothing owed is dropped without touching the pipeline.
   assign adv         = fire && (!in_flush_ff || (pending_ff != '0));
   assign restart_now = !in_flush_ff && done_ff;
   assign col_use     = restart_now ? '0 : col_ff;
   assign row_use     = restart_now ? '0 : row_ff;
   assign v           = in_flush_ff ? '0 : in_sample_ff;

   assign wrap    = (LEN_W'(col_use) == len_ff - LEN_W'(1));
   assign col_nxt = wrap ? '0 : COL_W'(col_use + COL_W'(1));
   assign row_nxt = row_use + ROW_W'(wrap);

   // Position of the result that leaves with this step: one line plus one
   // sample behind the input position.
   assign have_out = (row_use >= ROW_W'(2)) || ((row_use == ROW_W'(1)) && (col_use != '0));
   assign orow     = (col_use != '0) ? row_use - ROW_W'(1) : row_use - ROW_W'(2);
   assign ocol     = (col_use != '0) ? LEN_W'(col_use) - LEN_W'(1) : len_ff - LEN_W'(1);
   assign interior = (orow >= ROW_W'(1)) && (orow <= cnt_ff - ROW_W'(2)) &&
                     (ocol >= LEN_W'(1)) && (ocol <= len_ff - LEN_W'(2));
   assign is_last  = (orow == cnt_ff - ROW_W'(1)) && (ocol == len_ff - LEN_W'(1));

   // Kernel: corners once, edges twice, center four times.
   assign corner_sum = SUM_W'(window_ff[3]) + SUM_W'(window_ff[5]) +
                       SUM_W'(rd_up_ff) + SUM_W'(v);
   assign edge_sum   = SUM_W'(window_ff[0]) + SUM_W'(window_ff[2]) +
                       SUM_W'(window_ff[4]) + SUM_W'(rd_mid_ff);
   assign kernel_sum = corner_sum + (edge_sum << 1) + (SUM_W'(window_ff[1]) << 2);
   assign out_value  = interior ? kernel_sum[SUM_W-1:4] : window_ff[1];

   // Register values are clamped once, when written.
   assign len_wr = 32'(csr_if.data[LEN_REG_W-1:0]);
   assign cnt_wr = 32'(csr_if.data[CNT_REG_W-1:0]);
   always_comb begin
      if (len_wr < 32'(MIN_DIM)) begin
         len_clamped = LEN_W'(MIN_DIM);
      end else if (len_wr > 32'(MAX_LINE)) begin
         len_clamped = LEN_W'(MAX_LINE);
      end else begin
         len_clamped = LEN_W'(len_wr);
      end
      if (cnt_wr < 32'(MIN_DIM)) begin
         cnt_clamped = ROW_W'(MIN_DIM);
      end else if (cnt_wr > 32'(MAX_LINES)) begin
         cnt_clamped = ROW_W'(MAX_LINES);
      end else begin
         cnt_clamped = ROW_W'(cnt_wr);
      end
   end

   // Next grid position and drain state.
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      pending_in = pending_ff;
      done_in    = done_ff;
      if (csr_wr) begin
         col_in     = '0;
         row_in     = '0;
         pending_in = '0;
         done_in    = 1'b0;
      end else if (adv) begin
         col_in = col_nxt;
         row_in = row_nxt;
         if (in_flush_ff) begin
            pending_in = pending_ff - PEND_W'(1);
         end else if (row_nxt >= cnt_ff) begin
            // Last sample of the grid: line_length + 1 results are still owed.
            done_in    = 1'b1;
            pending_in = PEND_W'(len_ff) + PEND_W'(1);
         end else begin
            done_in    = 1'b0;
            pending_in = '0;
         end
      end
   end

   // The line store read runs one step ahead, at the column of the next step.
   // After a restart on a new grid the data read is stale, but it only reaches
   // the first line, whose results are all border values.
   always_comb begin
      if (csr_wr) begin
         rd_addr = '0;
      end else if (adv) begin
         rd_addr = col_nxt;
      end else begin
         rd_addr = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         store_up_mem[col_use]  <= rd_mid_ff;
         store_mid_mem[col_use] <= v;
      end
      rd_up_ff  <= store_up_mem[rd_addr];
      rd_mid_ff <= store_mid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_sample_ff <= req_if.sample;
         in_flush_ff  <= req_if.is_flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
         done_ff    <= 1'b0;
         len_ff     <= LEN_W'(LEN_RESET);
         cnt_ff     <= ROW_W'(CNT_RESET);
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
         done_ff    <= done_in;
         if (csr_wr && (csr_if.index == CSR_LINE_LENGTH)) begin
            len_ff <= len_clamped;
         end
         if (csr_wr && (csr_if.index == CSR_LINE_COUNT)) begin
            cnt_ff <= cnt_clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (adv) begin
         window_ff[3] <= window_ff[0];
         window_ff[4] <= window_ff[1];
         window_ff[5] <= window_ff[2];
         window_ff[0] <= rd_up_ff;
         window_ff[1] <= rd_mid_ff;
         window_ff[2] <= v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && have_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && have_out) begin
         rsp_smoothed_ff <= out_value;
         rsp_last_ff     <= is_last;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.smoothed   = rsp_smoothed_ff;
   assign rsp_if.frame_last = rsp_last_ff;

endmodule

// File: tb/sv/tb_binomial_blur_3x3_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for binomial_blur_3x3_top: streams height grids through
// the request channel and checks every response against a local blur predictor.
// Depends on bb3_pkg, the channel interfaces in bb3_if.sv and the block itself.
module tb_binomial_blur_3x3_top;
   import bb3_pkg::*;

   localparam int          LINE_MAX      = 256;    // MAX_LINE given to the block
   localparam int unsigned SETTLE_CYCLES = 8;      // settling wait after the queues run empty
   localparam int unsigned HOLD_CYCLES   = 150;    // one long receiver hold-off
   localparam int unsigned RANDOM_ITEMS  = 480;
   localparam int unsigned CALM_ITEMS    = 150;    // tail of the run without idling
   localparam int unsigned CYCLE_LIMIT   = 600000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                is_flush;
   } height_req_t;

   typedef struct packed {
      logic [SAMPLE_W-1:0] smoothed;
      logic                frame_last;
   } blur_out_t;

   logic clock;
   logic reset;

   bb3_req_if req_bus ();
   bb3_rsp_if rsp_bus ();
   bb3_csr_if csr_bus ();

   binomial_blur_3x3_top #(.MAX_LINE(LINE_MAX)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Requests waiting for the driver, and smoothed values the block still owes.
   height_req_t pending_requests[$];
   blur_out_t   smoothed_due[$];

   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   int unsigned src_idle_pct = 0;
   int unsigned snk_idle_pct = 0;
   int unsigned src_gap      = 0;
   int unsigned snk_gap      = 0;
   int unsigned hold_left    = 0;
   bit          calm_tail    = 1'b0;
   bit          hold_arm     = 1'b0;
   bit          hold_used    = 1'b0;

   // ------------------------------------------------------------------------
   // Blur predictor. It mirrors the block's configuration, both line stores,
   // the 3x2 window and the input position. The window holds the newest column
   // in entries 0..2 (top, middle, bottom) and the column before it in 3..5.
   // ------------------------------------------------------------------------
   logic [LEN_REG_W-1:0] cfg_length = 9'd256;
   logic [CNT_REG_W-1:0] cfg_count  = 11'd256;
   logic [SAMPLE_W-1:0]  upper_line  [LINE_MAX];
   logic [SAMPLE_W-1:0]  middle_line [LINE_MAX];
   logic [SAMPLE_W-1:0]  win [6];
   int unsigned          col_pos       = 0;
   int unsigned          row_pos       = 0;
   int unsigned          owed          = 0;
   bit                   grid_complete = 1'b0;

   // Registers are clamped to their legal ranges only when they are used.
   function automatic int unsigned line_span();
      int unsigned v;
      v = 32'(cfg_length);
      if (v < MIN_DIM) v = MIN_DIM;
      if (v > LINE_MAX) v = LINE_MAX;
      return v;
   endfunction

   function automatic int unsigned line_total();
      int unsigned v;
      v = 32'(cfg_count);
      if (v < MIN_DIM) v = MIN_DIM;
      if (v > MAX_LINES) v = MAX_LINES;
      return v;
   endfunction

   // A restart drops owed results; the line stores and the window keep their data.
   function automatic void restart_grid();
      col_pos       = 0;
      row_pos       = 0;
      owed          = 0;
      grid_complete = 1'b0;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0]  value);
      case (idx)
         CSR_LINE_LENGTH: cfg_length = value[LEN_REG_W-1:0];
         CSR_LINE_COUNT:  cfg_count  = value[CNT_REG_W-1:0];
         default: ;
      endcase
      restart_grid();
   endfunction

   // Shifts one column value into the window. Once a full line plus one sample
   // has gone in, the position one line and one sample back is complete and
   // its result is owed: the kernel sum for interior positions, the raw centre
   // value on the grid border.
   function automatic void push_column(input logic [SAMPLE_W-1:0] v);
      int unsigned         len;
      int unsigned         cnt;
      int unsigned         c;
      int unsigned         n;
      int unsigned         pos;
      int unsigned         orow;
      int unsigned         ocol;
      logic [SAMPLE_W-1:0] above;
      logic [SAMPLE_W-1:0] mid_v;
      logic [SAMPLE_W-1:0] val;
      logic [SUM_W-1:0]    acc;
      blur_out_t           r;
      len = line_span();
      cnt = line_total();
      c   = col_pos;
      n   = row_pos * len + c;
      if (c >= len) c = 0;
      above = upper_line[c];
      mid_v = middle_line[c];
      if (n >= len + 1) begin
         pos  = n - len - 1;
         orow = pos / len;
         ocol = pos % len;
         val  = win[1];
         if (orow >= 1 && orow + 2 <= cnt && ocol >= 1 && ocol + 2 <= len) begin
            acc = SUM_W'(win[3] + win[5] + above + v
                + 2 * (win[0] + win[2] + win[4] + mid_v)
                + 4 * win[1]);
            val = acc[SUM_W-1:4];
         end
         r.smoothed   = val;
         r.frame_last = (pos == cnt * len - 1);
         smoothed_due.push_back(r);
      end
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = above;
      win[1] = mid_v;
      win[2] = v;
      upper_line[c]  = mid_v;
      middle_line[c] = v;
      c++;
      if (c >= len) begin
         c = 0;
         row_pos++;
      end
      col_pos = c;
   endfunction

   // One accepted request. A flush only counts while results are owed after the
   // last sample of a grid, and then pushes a zero column through the window.
   // A sample after a finished grid starts the next grid from position zero.
   function automatic void predict_smoothing(input logic [SAMPLE_W-1:0] height,
                                             input logic                flush);
      if (flush) begin
         if (owed == 0) return;
         owed--;
         push_column('0);
         return;
      end
      if (grid_complete) restart_grid();
      push_column(height);
      if (row_pos >= line_total()) begin
         grid_complete = 1'b1;
         owed          = line_span() + 1;
      end
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Clock, and known values on every block input from time zero.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.sample   = '0;
      req_bus.is_flush = 1'b0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_LINE_LENGTH;
      csr_bus.data     = '0;
   end

   // Run limit: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver. Every accepted request goes through the predictor at the
   // edge where it is accepted. A new request is only put up when the channel
   // is free, and idling comes in random bursts; valid gets at most
   // one nonblocking assignment per edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      height_req_t nxt;
      logic        offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         src_gap       <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_smoothing(req_bus.sample, req_bus.is_flush);
         if (!req_bus.valid || req_bus.ready) begin
            offer = 1'b0;
            if (src_gap != 0) begin
               src_gap <= src_gap - 1;
            end else if (!calm_tail && $urandom_range(99) < src_idle_pct) begin
               src_gap <= $urandom_range(6);
            end else if (pending_requests.size() != 0) begin
               nxt              = pending_requests.pop_front();
               req_bus.sample   <= nxt.sample;
               req_bus.is_flush <= nxt.is_flush;
               offer            = 1'b1;
            end
            req_bus.valid <= offer;
         end
      end
   end

   // The one long hold-off: armed by the stimulus, it starts as soon as a
   // response is waiting, so the block fills up and has to stall its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_used && rsp_bus.valid) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor. Each accepted response is checked field by field
   // against the oldest owed result; ready idles in random bursts as well.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      blur_out_t exp_out;
      logic      take;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         snk_gap       <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (smoothed_due.size() == 0) begin
               report_mismatch($sformatf("response with nothing owed: smoothed=%h frame_last=%b",
                                         rsp_bus.smoothed, rsp_bus.frame_last));
            end else begin
               exp_out = smoothed_due.pop_front();
               if (rsp_bus.smoothed !== exp_out.smoothed)
                  report_mismatch($sformatf("smoothed %h, expected %h",
                                            rsp_bus.smoothed, exp_out.smoothed));
               if (rsp_bus.frame_last !== exp_out.frame_last)
                  report_mismatch($sformatf("frame_last %b, expected %b (smoothed %h)",
                                            rsp_bus.frame_last, exp_out.frame_last,
                                            exp_out.smoothed));
            end
         end
         take = 1'b1;
         if (snk_gap != 0) begin
            snk_gap <= snk_gap - 1;
            take    = 1'b0;
         end else if (!calm_tail && $urandom_range(99) < snk_idle_pct) begin
            snk_gap <= $urandom_range(6);
            take    = 1'b0;
         end
         rsp_bus.ready <= take && (hold_left == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic logic [SAMPLE_W-1:0] pick_height();
      logic [SAMPLE_W-1:0] h;
      case ($urandom_range(9))
         0:       h = '0;
         1:       h = '1;
         default: h = SAMPLE_W'($urandom);
      endcase
      return h;
   endfunction

   function automatic int unsigned pick_idle();
      case ($urandom_range(2))
         0:       return 0;
         1:       return 15;
         default: return 40;
      endcase
   endfunction

   function automatic void queue_request(input logic [SAMPLE_W-1:0] h, input logic flush);
      height_req_t r;
      r.sample   = h;
      r.is_flush = flush;
      pending_requests.push_back(r);
   endfunction

   // Queues a run of samples, with stray flushes scattered between them that
   // the block must ignore, followed by a number of draining flushes.
   function automatic void queue_grid(input int unsigned samples, input int unsigned drain,
                                      input int unsigned stray_pct);
      for (int unsigned k = 0; k < samples; k++) begin
         if (k > 0 && $urandom_range(99) < stray_pct) queue_request(pick_height(), 1'b1);
         queue_request(pick_height(), 1'b0);
      end
      repeat (drain) queue_request(pick_height(), 1'b1);
   endfunction

   // Waits until every request is taken and every owed result has come, then
   // gives a request that causes no result time to leave the pipeline. The
   // check runs on the falling edge, when the driver and monitor have settled.
   task automatic settle();
      while (pending_requests.size() != 0 || req_bus.valid || smoothed_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Valid stays high between back-to-back writes and is lowered once at the end.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0]  value);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_register(idx, value);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] len_word,
                            input logic [CSR_DATA_W-1:0] cnt_word);
      settle();
      write_register(CSR_LINE_LENGTH, len_word);
      write_register(CSR_LINE_COUNT, cnt_word);
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] len_word;
      logic [CSR_DATA_W-1:0] cnt_word;
      int unsigned           random_items;
      int unsigned           span;
      int unsigned           total;
      int unsigned           grids;
      int unsigned           mode;
      int unsigned           drain;
      int unsigned           part;
      random_items = 0;
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration is 256 by 256. A bit more than one line of
      // samples brings out the first results of the top border line. The
      // receiver holds off for a long stretch once the first of them is up,
      // while the sender keeps offering, so the block fills and stalls.
      src_idle_pct <= 0;
      snk_idle_pct <= 10;
      hold_arm     <= 1'b1;
      queue_grid(300, 0, 3);

      // Directed part on the smallest grid, 3 by 3, whose only interior
      // position is the centre. A flush with nothing owed comes first; the
      // first grid is all full-scale, which also checks the sum width, and has
      // a stray flush in the middle that must be ignored. Two draining flushes
      // then leave results owed, and the next grid's first sample drops them.
      // The second grid is a checkerboard, drained fully plus one extra flush.
      configure(11'd3, 11'd3);
      src_idle_pct <= 20;
      snk_idle_pct <= 20;
      queue_request(16'h1234, 1'b1);
      for (int k = 0; k < 9; k++) begin
         if (k == 4) queue_request(16'hFFFF, 1'b1);
         queue_request(16'hFFFF, 1'b0);
      end
      repeat (2) queue_request(16'h0000, 1'b1);
      for (int k = 0; k < 9; k++) queue_request((k % 2 == 0) ? 16'hFFFF : 16'h0000, 1'b0);
      repeat (5) queue_request(16'hA5A5, 1'b1);

      // Most lines: all-ones clamps the count to 1024, and the length word has
      // only its upper unused bits set, so the length falls back to 3. Part of
      // the grid is enough; the next register write restarts it.
      configure(11'h600, 11'h7FF);
      src_idle_pct <= 5;
      snk_idle_pct <= 5;
      queue_grid(90, 0, 2);

      // Random part: small grids under changing settings, mostly complete and
      // fully drained, some cut short while draining or in the middle.
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) calm_tail <= 1'b1;
         case ($urandom_range(9))
            0:       len_word = CSR_DATA_W'($urandom_range(2));
            1:       len_word = CSR_DATA_W'(MIN_DIM);
            2:       len_word = CSR_DATA_W'($urandom_range(24, 11));
            default: len_word = CSR_DATA_W'($urandom_range(10, 3));
         endcase
         len_word[CSR_DATA_W-1:LEN_REG_W] = (CSR_DATA_W - LEN_REG_W)'($urandom_range(3));
         case ($urandom_range(9))
            0:       cnt_word = CSR_DATA_W'($urandom_range(2));
            1:       cnt_word = CSR_DATA_W'(MIN_DIM);
            default: cnt_word = CSR_DATA_W'($urandom_range(6, 3));
         endcase
         configure(len_word, cnt_word);
         src_idle_pct <= pick_idle();
         snk_idle_pct <= pick_idle();
         span  = line_span();
         total = span * line_total();
         grids = $urandom_range(3, 1);
         for (int unsigned g = 0; g < grids; g++) begin
            mode = $urandom_range(9);
            if (mode < 7) begin
               drain = span + 1 + (($urandom_range(3) == 0) ? 1 : 0);
               queue_grid(total, drain, 8);
               random_items += total + span + 1;
            end else if (mode < 9) begin
               // The next grid starts while results are still owed.
               drain = $urandom_range(span);
               queue_grid(total, drain, 8);
               random_items += total + drain;
            end else begin
               // Cut off mid-grid; the next register write restarts it.
               part = $urandom_range(total - 1, 1);
               queue_grid(part, 0, 8);
               random_items += part;
               break;
            end
         end
      end

      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
